// File: hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit: command codes,
// controller states and the command/status groups between the two halves.
// ----------------------------------------------------------------------------
package rau_pkg;

	// operand fields are read as two's complement in their low bits
	localparam int OPERAND_WIDTH = 32;
	localparam int FIELD_W       = 32;
	localparam int WIDE_W        = 64;
	localparam int DEN_W         = 63;
	localparam int SHIFT_W       = 7;
	localparam int COUNT_W       = 6;

	localparam logic [WIDE_W-1:0] MAG_MAX = {1'b0, {(WIDE_W-1){1'b1}}};

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_NEG = 3'd4
	} cmd_t;

	// which cross product the shared multiplier forms
	typedef enum logic [1:0] {
		MUL_LHS = 2'd0,
		MUL_RHS = 2'd1,
		MUL_NUM = 2'd2,
		MUL_DEN = 2'd3
	} mul_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_LHS,
		S_MUL_RHS,
		S_MUL_NUM,
		S_MUL_DEN,
		S_COMBINE,
		S_GCD_LOAD,
		S_GCD,
		S_DIV_LOAD,
		S_DIV,
		S_FINISH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     combine;
		logic     gcd_load;
		logic     gcd_step;
		logic     div_load;
		logic     div_step;
		logic     out_load;
	} rau_ctrl_t;

	typedef struct packed {
		logic gcd_done;
		logic div_last;
	} rau_stat_t;

endpackage

// File: hdl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer of the rational arithmetic unit: steps the datapath through the
// cross products, the combine, the binary GCD and the reducing division.
// ----------------------------------------------------------------------------
module rau_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  rau_pkg::rau_stat_t  stat,
	output rau_pkg::rau_ctrl_t  ctrl
);

	rau_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rau_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		ctrl         = '0;
		ctrl.mul_sel = rau_pkg::MUL_LHS;
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		case (state_q)
			rau_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_d   = rau_pkg::S_MUL_LHS;
				end
			end
			rau_pkg::S_MUL_LHS: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = rau_pkg::MUL_LHS;
				state_d      = rau_pkg::S_MUL_RHS;
			end
			rau_pkg::S_MUL_RHS: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = rau_pkg::MUL_RHS;
				state_d      = rau_pkg::S_MUL_NUM;
			end
			rau_pkg::S_MUL_NUM: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = rau_pkg::MUL_NUM;
				state_d      = rau_pkg::S_MUL_DEN;
			end
			rau_pkg::S_MUL_DEN: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = rau_pkg::MUL_DEN;
				state_d      = rau_pkg::S_COMBINE;
			end
			rau_pkg::S_COMBINE: begin
				ctrl.combine = 1'b1;
				state_d      = rau_pkg::S_GCD_LOAD;
			end
			rau_pkg::S_GCD_LOAD: begin
				ctrl.gcd_load = 1'b1;
				state_d       = rau_pkg::S_GCD;
			end
			rau_pkg::S_GCD: begin
				if (stat.gcd_done) begin
					state_d = rau_pkg::S_DIV_LOAD;
				end else begin
					ctrl.gcd_step = 1'b1;
				end
			end
			rau_pkg::S_DIV_LOAD: begin
				ctrl.div_load = 1'b1;
				state_d       = rau_pkg::S_DIV;
			end
			rau_pkg::S_DIV: begin
				ctrl.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = rau_pkg::S_FINISH;
				end
			end
			rau_pkg::S_FINISH: begin
				ctrl.out_load = 1'b1;
				state_d       = rau_pkg::S_DONE;
			end
			rau_pkg::S_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = rau_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rau_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, shared multiplier, combine logic, binary GCD unit and a
// two-lane restoring divider that reduces numerator and denominator together.
// ----------------------------------------------------------------------------
module rau_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rau_pkg::rau_ctrl_t                  ctrl,
	output rau_pkg::rau_stat_t                  stat,
	input  logic [2:0]                          command,
	input  logic signed [rau_pkg::FIELD_W-1:0]  first_num,
	input  logic signed [rau_pkg::FIELD_W-1:0]  first_den,
	input  logic signed [rau_pkg::FIELD_W-1:0]  second_num,
	input  logic signed [rau_pkg::FIELD_W-1:0]  second_den,
	output logic signed [rau_pkg::WIDE_W-1:0]   result_num,
	output logic [rau_pkg::DEN_W-1:0]           result_den,
	output logic                                less_flag,
	output logic                                equal_flag,
	output logic                                error_flag
);

	localparam int OW = rau_pkg::OPERAND_WIDTH;
	localparam int WW = rau_pkg::WIDE_W;

	// operand sign and magnitude, taken from the low operand bits
	logic signed [OW-1:0] xn_w, xd_w, yn_w, yd_w;
	logic [OW-1:0]        xn_mag_q, xd_mag_q, yn_mag_q, yd_mag_q;
	logic                 xns_q, xds_q, yns_q, yds_q;
	logic [2:0]           cmd_q;

	assign xn_w = first_num[OW-1:0];
	assign xd_w = first_den[OW-1:0];
	assign yn_w = second_num[OW-1:0];
	assign yd_w = second_den[OW-1:0];

	// capture the item
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q    <= command;
			xns_q    <= xn_w[OW-1];
			xds_q    <= xd_w[OW-1];
			yns_q    <= yn_w[OW-1];
			yds_q    <= yd_w[OW-1];
			xn_mag_q <= xn_w[OW-1] ? OW'(-xn_w) : OW'(xn_w);
			xd_mag_q <= xd_w[OW-1] ? OW'(-xd_w) : OW'(xd_w);
			yn_mag_q <= yn_w[OW-1] ? OW'(-yn_w) : OW'(yn_w);
			yd_mag_q <= yd_w[OW-1] ? OW'(-yd_w) : OW'(yd_w);
		end
	end

	// shared multiplier, one cross product a cycle
	logic [OW-1:0]   mul_a, mul_b;
	logic [2*OW-1:0] mul_p;
	logic [WW-1:0]   lhs_q, rhs_q, num_q, den_q;
	logic            neg_q, err_q, less_q, equal_q;

	always_comb begin
		case (ctrl.mul_sel)
			rau_pkg::MUL_LHS: begin
				mul_a = xn_mag_q;
				mul_b = yd_mag_q;
			end
			rau_pkg::MUL_RHS: begin
				mul_a = yn_mag_q;
				mul_b = xd_mag_q;
			end
			rau_pkg::MUL_NUM: begin
				mul_a = xn_mag_q;
				mul_b = yn_mag_q;
			end
			default: begin
				mul_a = xd_mag_q;
				mul_b = (cmd_q == rau_pkg::CMD_DIV) ? yn_mag_q : yd_mag_q;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// sign-magnitude combine and comparison
	logic                xneg, yneg, yneg_add, in_err, bad_cmd, c_err;
	logic signed [WW:0]  lhs_s, rhs_s, rhs_add, sum_s;
	logic [WW-1:0]       sum_mag, c_num, c_den;
	logic                c_neg, c_less, c_equal;

	always_comb begin
		xneg     = xns_q ^ xds_q;
		yneg     = yns_q ^ yds_q;
		yneg_add = (cmd_q == rau_pkg::CMD_SUB) ? ~yneg : yneg;
		lhs_s    = xneg ? -$signed({1'b0, lhs_q}) : $signed({1'b0, lhs_q});
		rhs_s    = yneg ? -$signed({1'b0, rhs_q}) : $signed({1'b0, rhs_q});
		rhs_add  = yneg_add ? -$signed({1'b0, rhs_q}) : $signed({1'b0, rhs_q});
		sum_s    = lhs_s + rhs_add;
		sum_mag  = sum_s[WW] ? WW'(-sum_s) : WW'(sum_s);
		c_less   = lhs_s < rhs_s;
		c_equal  = lhs_s == rhs_s;
		in_err   = (xd_mag_q == '0) || (yd_mag_q == '0);
		bad_cmd  = 1'b0;
		c_neg    = 1'b0;
		c_num    = '0;
		c_den    = den_q;
		case (cmd_q)
			rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
				c_neg = sum_s[WW];
				c_num = sum_mag;
			end
			rau_pkg::CMD_MUL: begin
				c_neg = xneg ^ yneg;
				c_num = num_q;
			end
			rau_pkg::CMD_DIV: begin
				c_neg = xneg ^ yneg;
				c_num = lhs_q;
			end
			rau_pkg::CMD_NEG: begin
				c_neg = ~xneg;
				c_num = WW'(xn_mag_q);
				c_den = WW'(xd_mag_q);
			end
			default: begin
				bad_cmd = 1'b1;
			end
		endcase
		c_err = in_err || bad_cmd || (c_den == '0);
	end

	// binary GCD state
	logic [WW-1:0]                 u_q, v_q, div_q;
	logic [rau_pkg::SHIFT_W-1:0]   k_q;

	// two-lane restoring divider state
	logic [WW:0]                   rn_q, rd_q, rn_sh, rd_sh;
	logic [WW-1:0]                 qn_q, qd_q;
	logic [rau_pkg::COUNT_W-1:0]   cnt_q;
	logic                          rn_ge, rd_ge;

	assign rn_sh = {rn_q[WW-1:0], qn_q[WW-1]};
	assign rd_sh = {rd_q[WW-1:0], qd_q[WW-1]};
	assign rn_ge = rn_sh >= {1'b0, div_q};
	assign rd_ge = rd_sh >= {1'b0, div_q};

	assign stat = '{gcd_done: (u_q == '0) || (v_q == '0), div_last: &cnt_q};

	// datapath registers
	always_ff @(posedge clk) begin
		// hold a cross product
		if (ctrl.mul_en) begin
			case (ctrl.mul_sel)
				rau_pkg::MUL_LHS: lhs_q <= WW'(mul_p);
				rau_pkg::MUL_RHS: rhs_q <= WW'(mul_p);
				rau_pkg::MUL_NUM: num_q <= WW'(mul_p);
				default:          den_q <= WW'(mul_p);
			endcase
		end
		// form the raw result, or 0/1 on error
		if (ctrl.combine) begin
			err_q   <= c_err;
			less_q  <= in_err ? 1'b0 : c_less;
			equal_q <= in_err ? 1'b0 : c_equal;
			if (c_err) begin
				num_q <= '0;
				den_q <= WW'(1);
				neg_q <= 1'b0;
			end else begin
				num_q <= c_num;
				den_q <= c_den;
				neg_q <= c_neg && (c_num != '0);
			end
		end
		// binary GCD: strip common twos, then subtract odd values
		if (ctrl.gcd_load) begin
			u_q <= num_q;
			v_q <= den_q;
			k_q <= '0;
		end else if (ctrl.gcd_step) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end
		// divide both lanes by the GCD, one quotient bit a cycle
		if (ctrl.div_load) begin
			div_q <= (u_q | v_q) << k_q;
			rn_q  <= '0;
			rd_q  <= '0;
			qn_q  <= num_q;
			qd_q  <= den_q;
			cnt_q <= '0;
		end else if (ctrl.div_step) begin
			rn_q  <= rn_ge ? rn_sh - {1'b0, div_q} : rn_sh;
			rd_q  <= rd_ge ? rd_sh - {1'b0, div_q} : rd_sh;
			qn_q  <= {qn_q[WW-2:0], rn_ge};
			qd_q  <= {qd_q[WW-2:0], rd_ge};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			less_flag  <= 1'b0;
			equal_flag <= 1'b0;
			error_flag <= 1'b0;
		end else if (ctrl.out_load) begin
			less_flag  <= less_q;
			equal_flag <= equal_q;
			error_flag <= err_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			if (qn_q[WW-1]) begin
				result_num <= neg_q ? -$signed(rau_pkg::MAG_MAX) : $signed(rau_pkg::MAG_MAX);
			end else begin
				result_num <= neg_q ? -$signed(qn_q) : $signed(qn_q);
			end
			result_den <= qd_q[rau_pkg::DEN_W-1:0];
		end
	end

endmodule

// File: hdl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies, divides or negates signed fractions and
// returns the result reduced to lowest terms with comparison flags.
// ----------------------------------------------------------------------------
// One item is worked at a time from accept to result: four cross products on
// one shared 32x32 multiplier, a binary GCD that retires one shift or
// subtract a cycle on the two 64-bit values, then a two-lane restoring
// divider that reduces numerator and denominator together, plus load and
// hand-over steps. in_ready is high only while the unit is empty; the result
// stays on the output until taken. A zero operand denominator, division by
// zero or an unknown command gives 0/1 with error_flag set.
module rational_arithmetic_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0]                          command,
	input  logic signed [rau_pkg::FIELD_W-1:0]  first_num,
	input  logic signed [rau_pkg::FIELD_W-1:0]  first_den,
	input  logic signed [rau_pkg::FIELD_W-1:0]  second_num,
	input  logic signed [rau_pkg::FIELD_W-1:0]  second_den,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [rau_pkg::WIDE_W-1:0]   result_num,
	output logic [rau_pkg::DEN_W-1:0]           result_den,
	output logic                                less_flag,
	output logic                                equal_flag,
	output logic                                error_flag
);

	rau_pkg::rau_ctrl_t ctrl;
	rau_pkg::rau_stat_t stat;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	rau_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stat       (stat),
		.command    (command),
		.first_num  (first_num),
		.first_den  (first_den),
		.second_num (second_num),
		.second_den (second_den),
		.result_num (result_num),
		.result_den (result_den),
		.less_flag  (less_flag),
		.equal_flag (equal_flag),
		.error_flag (error_flag)
	);

endmodule
